// ----- rtl/tfn_pkg.sv -----
// shared types, constants and the seed table for the triangle face normal block
// depends on nothing; used by triangle_face_normal_top and tfn_newton
package tfn_pkg;

  localparam int COORD_WIDTH_DEF      = 24;
  localparam int RSQRT_ITERATIONS_DEF = 3;
  localparam int EDGE_LIMIT           = 30;  // coordinates wider than this drop low edge bits; edges keep 31 bits
  localparam int NORM_MSB             = 29;  // largest magnitude lands in [2^29, 2^30)
  localparam int MAG_W                = 30;
  localparam int X_W                  = 32;
  localparam int Y_W                  = 31;
  localparam int OUT_W                = 16;

  // one item in the reciprocal square root section
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  deg;
    logic                  last;
    logic                  e_hi;   // sum of squares has 61 or 62 bits
    logic [X_W-1:0]        x;      // Q0.32
    logic [Y_W-1:0]        y;      // Q1.30 estimate
  } item_t;

  // seed in Q1.30 from the top three bits of x
  function automatic logic [Y_W-1:0] seed_lookup(input logic [2:0] idx);
    logic [6:0] s;
    case (idx)
      3'd3:    s = 7'd97;
      3'd4:    s = 7'd85;
      3'd5:    s = 7'd77;
      3'd6:    s = 7'd71;
      3'd7:    s = 7'd66;
      default: s = 7'd114;
    endcase
    return {s, 24'd0};
  endfunction

endpackage

// ----- rtl/triangle_face_normal_top.sv -----
// Unit face normal of a stream of triangles. One triangle enters per clock while
// the output is not stalled; its normal passes through the pipeline in order:
// edge subtract, cross product, normalize,
// sum of squares, three multiplier stages per newton step and the final scaling.
// Any stall on the output only fills bubbles behind it. A triangle whose cross
// product is zero gives an all-zero normal with out_tuser high.
// depends on tfn_pkg and tfn_newton
module triangle_face_normal_top #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int RSQRT_ITERATIONS = tfn_pkg::RSQRT_ITERATIONS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz from bit 0 up, zero padded
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // nx, ny, nz from bit 0 up
  output logic [47:0]                           out_tdata,
  // degenerate
  output logic                                  out_tuser,
  output logic                                  out_tlast
);

  localparam int CW   = COORD_WIDTH;
  localparam int ESH  = (CW > tfn_pkg::EDGE_LIMIT) ? CW - tfn_pkg::EDGE_LIMIT : 0;
  localparam int EW   = CW + 1 - ESH;
  localparam int PW   = 2 * EW;
  localparam int MW   = PW + 1;
  localparam int PSW  = $clog2(MW);
  localparam int SW   = MW + tfn_pkg::MAG_W;
  localparam int N    = RSQRT_ITERATIONS;
  localparam int MAGW = tfn_pkg::MAG_W;

  // enables and valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

  logic [N:0]     ch_valid, ch_ready;
  tfn_pkg::item_t ch_item [0:N];

  assign en9       = !out_valid_r || out_tready;
  assign en8       = !v8_r || en9;
  assign ch_ready[N] = en8;
  assign en7       = !v7_r || ch_ready[0];
  assign en6       = !v6_r || en7;
  assign en5       = !v5_r || en6;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= ch_valid[N];
      if (en9) out_valid_r <= v8_r;
    end
  end

  // stage 1: edge vectors from the first vertex
  logic signed [EW-1:0] e1_r [3], e2_r [3], e1_nxt [3], e2_nxt [3];
  logic                 last1_r;
  always_comb begin
    logic [CW-1:0] a, b, c;
    logic [CW:0]   db, dc;
    for (int i = 0; i < 3; i++) begin
      a  = in_tdata[i*CW +: CW];
      b  = in_tdata[(3+i)*CW +: CW];
      c  = in_tdata[(6+i)*CW +: CW];
      db = {b[CW-1], b} - {a[CW-1], a};
      dc = {c[CW-1], c} - {a[CW-1], a};
      e1_nxt[i] = db[CW:ESH];
      e2_nxt[i] = dc[CW:ESH];
    end
  end

  // stage 2: six partial products
  logic signed [PW-1:0] pr_r [6];
  logic                 last2_r;

  // stage 3: cross components as sign and magnitude
  logic [MW-1:0] mag3_r [3], mag3_nxt [3];
  logic [2:0]    neg3_r, neg3_nxt;
  logic          deg3_r, last3_r;
  always_comb begin
    logic signed [MW-1:0] cr;
    for (int i = 0; i < 3; i++) begin
      cr          = MW'(pr_r[2*i]) - MW'(pr_r[2*i+1]);
      neg3_nxt[i] = cr[MW-1];
      mag3_nxt[i] = cr[MW-1] ? -cr : cr;
    end
  end

  // stage 4: leading one of the largest magnitude
  logic [MW-1:0]  mag4_r [3];
  logic [PSW-1:0] pos4_r, pos4_nxt;
  logic [2:0]     neg4_r;
  logic           deg4_r, last4_r;
  always_comb begin
    logic [MW-1:0] m;
    m = mag3_r[0];
    if (mag3_r[1] > m) m = mag3_r[1];
    if (mag3_r[2] > m) m = mag3_r[2];
    pos4_nxt = '0;
    for (int k = 0; k < MW; k++)
      if (m[k]) pos4_nxt = PSW'(k);
  end

  // stage 5: common shift into [2^29, 2^30)
  logic [MAGW-1:0] mag5_r [3], mag5_nxt [3];
  logic [2:0]      neg5_r;
  logic            deg5_r, last5_r;
  always_comb begin
    logic [SW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      ext = SW'(mag4_r[i]);
      if (32'(pos4_r) >= tfn_pkg::NORM_MSB)
        ext = ext >> (pos4_r - PSW'(tfn_pkg::NORM_MSB));
      else
        ext = ext << (PSW'(tfn_pkg::NORM_MSB) - pos4_r);
      mag5_nxt[i] = ext[MAGW-1:0];
    end
  end

  // stage 6: squares
  logic [2*MAGW-1:0] sq6_r [3];
  logic [MAGW-1:0]   mag6_r [3];
  logic [2:0]        neg6_r;
  logic              deg6_r, last6_r;

  // stage 7: sum of squares, x in Q0.32 and the seed
  tfn_pkg::item_t it7_nxt, it7_r;
  always_comb begin
    logic [61:0] s;
    s = 62'(sq6_r[0]) + 62'(sq6_r[1]) + 62'(sq6_r[2]);
    it7_nxt.mag  = {mag6_r[2], mag6_r[1], mag6_r[0]};
    it7_nxt.neg  = neg6_r;
    it7_nxt.deg  = deg6_r;
    it7_nxt.last = last6_r;
    it7_nxt.e_hi = |s[61:60];
    it7_nxt.x    = it7_nxt.e_hi ? s[61:30] : s[59:28];
    it7_nxt.y    = tfn_pkg::seed_lookup(it7_nxt.x[31:29]);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      e1_r <= e1_nxt; e2_r <= e2_nxt; last1_r <= in_tlast;
    end
    if (en2) begin
      pr_r[0] <= e1_r[1] * e2_r[2];
      pr_r[1] <= e1_r[2] * e2_r[1];
      pr_r[2] <= e1_r[2] * e2_r[0];
      pr_r[3] <= e1_r[0] * e2_r[2];
      pr_r[4] <= e1_r[0] * e2_r[1];
      pr_r[5] <= e1_r[1] * e2_r[0];
      last2_r <= last1_r;
    end
    if (en3) begin
      mag3_r  <= mag3_nxt;
      neg3_r  <= neg3_nxt;
      deg3_r  <= (mag3_nxt[0] == '0) && (mag3_nxt[1] == '0) && (mag3_nxt[2] == '0);
      last3_r <= last2_r;
    end
    if (en4) begin
      mag4_r <= mag3_r; pos4_r <= pos4_nxt; neg4_r <= neg3_r;
      deg4_r <= deg3_r; last4_r <= last3_r;
    end
    if (en5) begin
      mag5_r <= mag5_nxt; neg5_r <= neg4_r; deg5_r <= deg4_r; last5_r <= last4_r;
    end
    if (en6) begin
      for (int i = 0; i < 3; i++) sq6_r[i] <= 60'(mag5_r[i]) * 60'(mag5_r[i]);
      mag6_r <= mag5_r; neg6_r <= neg5_r; deg6_r <= deg5_r; last6_r <= last5_r;
    end
    if (en7) it7_r <= it7_nxt;
  end

  // newton steps
  assign ch_valid[0] = v7_r;
  assign ch_item[0]  = it7_r;
  for (genvar g = 0; g < N; g++) begin : g_newton
    tfn_newton u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ch_valid[g]),
      .in_ready  (ch_ready[g]),
      .in_item   (ch_item[g]),
      .out_valid (ch_valid[g+1]),
      .out_ready (ch_ready[g+1]),
      .out_item  (ch_item[g+1])
    );
  end

  // stage 8: magnitude times inverse length
  logic [60:0] pm8_r [3];
  logic [2:0]  neg8_r;
  logic        deg8_r, last8_r, ehi8_r;
  always_ff @(posedge clk) begin
    if (en8) begin
      for (int i = 0; i < 3; i++)
        pm8_r[i] <= 61'(ch_item[N].mag[i]) * 61'(ch_item[N].y);
      neg8_r  <= ch_item[N].neg;
      deg8_r  <= ch_item[N].deg;
      last8_r <= ch_item[N].last;
      ehi8_r  <= ch_item[N].e_hi;
    end
  end

  // stage 9: round, sign and saturate into the output word
  logic [47:0] data_nxt, data_r;
  logic        deg_r, last_r;
  always_comb begin
    logic [61:0] rnd, q;
    logic [15:0] r;
    for (int i = 0; i < 3; i++) begin
      rnd = 62'(pm8_r[i]) + (ehi8_r ? (62'd1 << 45) : (62'd1 << 44));
      q   = ehi8_r ? (rnd >> 46) : (rnd >> 45);
      if (neg8_r[i]) begin
        if (q > 62'd32768) q = 62'd32768;
        r = -q[15:0];
      end else begin
        if (q > 62'd32767) q = 62'd32767;
        r = q[15:0];
      end
      data_nxt[i*16 +: 16] = deg8_r ? 16'd0 : r;
    end
  end

  always_ff @(posedge clk) begin
    if (en9) begin
      data_r <= data_nxt; deg_r <= deg8_r; last_r <= last8_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = deg_r;
  assign out_tlast  = last_r;

endmodule

// ----- rtl/tfn_newton.sv -----
// one newton step of the inverse square root, three register stages
// depends on tfn_pkg
module tfn_newton (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tfn_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output tfn_pkg::item_t out_item
);

  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;

  logic           va_r, vb_r, vc_r;
  logic           en_a, en_b, en_c;
  tfn_pkg::item_t ia_r, ib_r, ic_r;
  logic [31:0]    y2_r, t_r;
  logic [61:0]    sq;
  logic [63:0]    xt;
  logic [31:0]    d;
  logic [62:0]    yd;
  tfn_pkg::item_t ic_nxt;

  // per-stage load enables
  assign en_c     = !vc_r || out_ready;
  assign en_b     = !vb_r || en_c;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
      if (en_c) vc_r <= vb_r;
    end
  end

  // stage a: y squared
  assign sq = 62'(in_item.y) * 62'(in_item.y);

  // stage b: x times y squared
  assign xt = 64'(ia_r.x) * 64'(y2_r);

  // stage c: 3 - t, then scale y
  always_comb begin
    ic_nxt = ib_r;
    d      = (t_r > THREE_Q30) ? 32'd0 : THREE_Q30 - t_r;
    yd     = 63'(ib_r.y) * 63'(d);
    if (|yd[62:62]) ic_nxt.y = '1;
    else            ic_nxt.y = yd[61:31];
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ia_r <= in_item;
      y2_r <= sq[61:30];
    end
    if (en_b) begin
      ib_r <= ia_r;
      t_r  <= xt[63:32];
    end
    if (en_c) ic_r <= ic_nxt;
  end

  assign out_valid = vc_r;
  assign out_item  = ic_r;

endmodule

// ----- rtl/tfn_checker.sv -----
// port-level checks on the result channel of the face normal block
// depends on triangle_face_normal_top, to which it is bound
module tfn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // no word right after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("word valid after reset");

  // degenerate word carries a zero normal
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 48'd0)
    else $error("degenerate word with nonzero normal");

  // a unit normal always has a nonzero component
  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata != 48'd0)
    else $error("zero normal without degenerate flag");

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled word changed");

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
